@@ sv/tchp_pkg.sv @@
// Package: payload, command and configuration types and constants of the header parser.
`default_nettype none
package tchp_pkg;

   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] HEX_A_BASE = 8'h57;
   localparam logic [7:0] VERSION_INVALID = 8'hFF;

   localparam logic [5:0] HEADER_VALUE_BYTES = 6'd55;
   localparam logic [5:0] POS_SEP_VERSION    = 6'd2;
   localparam logic [5:0] POS_SEP_TRACE      = 6'd35;
   localparam logic [5:0] POS_SEP_PARENT     = 6'd52;
   localparam logic [5:0] POS_FINAL_FIELD    = 6'd54;
   localparam logic [5:0] POS_SATURATE       = 6'd63;

   localparam logic [8:0] COMMA_SATURATE = 9'd511;

   localparam logic [7:0] CSR_MAX_BYTES   = 8'd0;
   localparam logic [7:0] CSR_MAX_MEMBERS = 8'd1;

   localparam logic [9:0] MAX_BYTES_RESET   = 10'd512;
   localparam logic [7:0] MAX_MEMBERS_RESET = 8'd32;

   typedef enum logic [2:0] {
      CLS_VERSION,
      CLS_TRACE,
      CLS_SPAN,
      CLS_FLAGS,
      CLS_SEP,
      CLS_SKIP
   } cls_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        accepted;
      logic [7:0]  version;
      logic [63:0] trace_id_high;
      logic [63:0] trace_id_low;
      logic [63:0] span_id;
      logic [7:0]  flags;
   } rsp_type;

   typedef struct packed {
      logic       mode;
      logic       last;
      cls_type    cls;
      logic [3:0] nibble;
      logic       byte_ok;
      logic       long_enough;
      logic       comma;
   } cmd_type;

   typedef struct packed {
      logic [9:0] max_bytes;
      logic [7:0] max_members;
   } cfg_type;

endpackage
`default_nettype wire

@@ sv/tchp_fifo.sv @@
// Small register-based queue with count, used between front and back and at the result side.
`default_nettype none
module tchp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CW'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ sv/tchp_front.sv @@
// Front end: tracks the traceparent byte position and classifies each accepted byte.
`default_nettype none
module tchp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire tchp_pkg::req_type req,
   output tchp_pkg::cmd_type      cmd
);

   logic [5:0] pos_ff, pos_in;
   logic       is_digit, is_lower, hex_ok;
   logic [7:0] digit_sub, lower_sub;

   assign is_digit  = (req.data_byte >= tchp_pkg::CHAR_ZERO) &&
                      (req.data_byte <= tchp_pkg::CHAR_NINE);
   assign is_lower  = (req.data_byte >= tchp_pkg::CHAR_A) &&
                      (req.data_byte <= tchp_pkg::CHAR_F);
   assign hex_ok    = is_digit || is_lower;
   assign digit_sub = req.data_byte - tchp_pkg::CHAR_ZERO;
   assign lower_sub = req.data_byte - tchp_pkg::HEX_A_BASE;

   always_comb begin
      cmd             = '0;
      cmd.mode        = req.mode;
      cmd.last        = req.last;
      cmd.nibble      = is_digit ? digit_sub[3:0] : lower_sub[3:0];
      cmd.long_enough = (pos_ff >= tchp_pkg::POS_FINAL_FIELD);
      cmd.comma       = (req.data_byte == tchp_pkg::CHAR_COMMA);
      priority if (pos_ff == tchp_pkg::POS_SEP_VERSION ||
                   pos_ff == tchp_pkg::POS_SEP_TRACE ||
                   pos_ff == tchp_pkg::POS_SEP_PARENT ||
                   pos_ff == tchp_pkg::HEADER_VALUE_BYTES) begin
         cmd.cls = tchp_pkg::CLS_SEP;
      end else if (pos_ff > tchp_pkg::HEADER_VALUE_BYTES) begin
         cmd.cls = tchp_pkg::CLS_SKIP;
      end else if (pos_ff < tchp_pkg::POS_SEP_VERSION) begin
         cmd.cls = tchp_pkg::CLS_VERSION;
      end else if (pos_ff < tchp_pkg::POS_SEP_TRACE) begin
         cmd.cls = tchp_pkg::CLS_TRACE;
      end else if (pos_ff < tchp_pkg::POS_SEP_PARENT) begin
         cmd.cls = tchp_pkg::CLS_SPAN;
      end else begin
         cmd.cls = tchp_pkg::CLS_FLAGS;
      end
      if (req.mode) begin
         cmd.byte_ok = (req.data_byte >= tchp_pkg::CHAR_SPACE) &&
                       (req.data_byte != tchp_pkg::CHAR_DEL);
      end else if (cmd.cls == tchp_pkg::CLS_SEP) begin
         cmd.byte_ok = (req.data_byte == tchp_pkg::CHAR_DASH);
      end else if (cmd.cls == tchp_pkg::CLS_SKIP) begin
         cmd.byte_ok = 1'b1;
      end else begin
         cmd.byte_ok = hex_ok;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept && !req.mode) begin
         if (req.last) begin
            pos_in = '0;
         end else if (pos_ff != tchp_pkg::POS_SATURATE) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/tchp_back.sv @@
// Back end: accumulates fields and counts per mode and builds the verdict on the last byte.
`default_nettype none
module tchp_back #(
   parameter int COUNT_BITS = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tchp_pkg::cfg_type cfg,
   input  wire tchp_pkg::cmd_type cmd,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output tchp_pkg::rsp_type      rsp
);

   localparam int CW = (COUNT_BITS > 10) ? COUNT_BITS : 10;

   logic                  checks_ok_ff, checks_ok_in;
   logic                  trace_nz_ff, trace_nz_in;
   logic                  span_nz_ff, span_nz_in;
   logic [7:0]            version_ff, version_in;
   logic [63:0]           trace_hi_ff, trace_hi_in;
   logic [63:0]           trace_lo_ff, trace_lo_in;
   logic [63:0]           span_ff, span_in;
   logic [7:0]            flags_ff, flags_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [8:0]            comma_ff, comma_in;
   logic                  bytes_ok_ff, bytes_ok_in;

   logic                  parent_ok, state_ok;
   logic [COUNT_BITS-1:0] count_n;
   logic [8:0]            comma_n;
   logic                  bytes_ok_n;

   assign cmd_pop  = !cmd_empty && (!cmd.last || !rsp_full);
   assign rsp_push = cmd_pop && cmd.last;

   always_comb begin
      checks_ok_in = checks_ok_ff;
      trace_nz_in  = trace_nz_ff;
      span_nz_in   = span_nz_ff;
      version_in   = version_ff;
      trace_hi_in  = trace_hi_ff;
      trace_lo_in  = trace_lo_ff;
      span_in      = span_ff;
      flags_in     = flags_ff;
      count_n      = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
      comma_n      = (cmd.comma && comma_ff != tchp_pkg::COMMA_SATURATE) ?
                     comma_ff + 1'b1 : comma_ff;
      bytes_ok_n   = bytes_ok_ff && cmd.byte_ok;
      count_in     = count_ff;
      comma_in     = comma_ff;
      bytes_ok_in  = bytes_ok_ff;

      if (cmd_pop && !cmd.mode) begin
         checks_ok_in = checks_ok_ff && cmd.byte_ok;
         if (cmd.byte_ok) begin
            unique case (cmd.cls)
               tchp_pkg::CLS_VERSION: begin
                  version_in = {version_ff[3:0], cmd.nibble};
               end
               tchp_pkg::CLS_TRACE: begin
                  trace_hi_in = {trace_hi_ff[59:0], trace_lo_ff[63:60]};
                  trace_lo_in = {trace_lo_ff[59:0], cmd.nibble};
                  trace_nz_in = trace_nz_ff || (cmd.nibble != '0);
               end
               tchp_pkg::CLS_SPAN: begin
                  span_in    = {span_ff[59:0], cmd.nibble};
                  span_nz_in = span_nz_ff || (cmd.nibble != '0);
               end
               tchp_pkg::CLS_FLAGS: begin
                  flags_in = {flags_ff[3:0], cmd.nibble};
               end
               default: begin
               end
            endcase
         end
      end
      if (cmd_pop && cmd.mode) begin
         count_in    = count_n;
         comma_in    = comma_n;
         bytes_ok_in = bytes_ok_n;
      end

      parent_ok = checks_ok_in && cmd.long_enough &&
                  (version_in != tchp_pkg::VERSION_INVALID) && trace_nz_in && span_nz_in;
      state_ok  = bytes_ok_n && (count_n != '0) &&
                  (CW'(count_n) <= CW'(cfg.max_bytes)) &&
                  ((10'(comma_n) + 10'd1) <= 10'(cfg.max_members));

      rsp      = '0;
      rsp.kind = cmd.mode;
      if (cmd.mode) begin
         rsp.accepted = state_ok;
      end else if (parent_ok) begin
         rsp.accepted      = 1'b1;
         rsp.version       = version_in;
         rsp.trace_id_high = trace_hi_in;
         rsp.trace_id_low  = trace_lo_in;
         rsp.span_id       = span_in;
         rsp.flags         = flags_in;
      end

      if (cmd_pop && cmd.last && !cmd.mode) begin
         checks_ok_in = 1'b1;
         trace_nz_in  = 1'b0;
         span_nz_in   = 1'b0;
         version_in   = '0;
         trace_hi_in  = '0;
         trace_lo_in  = '0;
         span_in      = '0;
         flags_in     = '0;
      end
      if (cmd_pop && cmd.last && cmd.mode) begin
         count_in    = '0;
         comma_in    = '0;
         bytes_ok_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         checks_ok_ff <= 1'b1;
         trace_nz_ff  <= 1'b0;
         span_nz_ff   <= 1'b0;
         version_ff   <= '0;
         trace_hi_ff  <= '0;
         trace_lo_ff  <= '0;
         span_ff      <= '0;
         flags_ff     <= '0;
         count_ff     <= '0;
         comma_ff     <= '0;
         bytes_ok_ff  <= 1'b1;
      end else begin
         checks_ok_ff <= checks_ok_in;
         trace_nz_ff  <= trace_nz_in;
         span_nz_ff   <= span_nz_in;
         version_ff   <= version_in;
         trace_hi_ff  <= trace_hi_in;
         trace_lo_ff  <= trace_lo_in;
         span_ff      <= span_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         comma_ff     <= comma_in;
         bytes_ok_ff  <= bytes_ok_in;
      end
   end

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_push && (!rsp.accepted || rsp.kind) |->
         rsp.version == '0 && rsp.trace_id_high == '0 && rsp.trace_id_low == '0 &&
         rsp.span_id == '0 && rsp.flags == '0)
      else $error("verdict carries fields it must zero");

   a_parent_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_push && !cmd.mode |=> checks_ok_ff && !trace_nz_ff && !span_nz_ff)
      else $error("traceparent state not cleared after verdict");

   a_state_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_push && cmd.mode |=> count_ff == '0 && comma_ff == '0 && bytes_ok_ff)
      else $error("tracestate state not cleared after verdict");

endmodule
`default_nettype wire

@@ sv/trace_context_header_parser.sv @@
// Top level: trace-context header parser with front classifier, command queue, back end and result queue.
// One header value byte is taken per cycle at full rate; a verdict comes out on the last byte of each
// value, after that byte passes the command queue and then the back-end update into the result queue.
// The sustained rate of one byte per cycle is set by the back end, which updates its field shifters and
// counters for one queued byte per cycle; it stalls only when a verdict finds the result queue full, and
// the command queue then fills and raises req_full. Traceparent and tracestate bytes may interleave;
// each mode keeps its own state. Limits are set through the csr port (index 0 byte limit, index 1 member
// limit) by the user, only while the block is idle; the block itself does not enforce this.
`default_nettype none
module trace_context_header_parser #(
   parameter int COUNT_BITS = 11,
   parameter int CMD_DEPTH  = 4,
   parameter int RSP_DEPTH  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire tchp_pkg::req_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output tchp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_index,
   input  wire logic [9:0]        csr_data
);

   tchp_pkg::cfg_type cfg_ff, cfg_in;
   tchp_pkg::cmd_type front_cmd, back_cmd;
   tchp_pkg::rsp_type back_rsp;
   logic              accept, cmd_empty, cmd_pop, rsp_full, rsp_push;

   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == tchp_pkg::CSR_MAX_BYTES) begin
            cfg_in.max_bytes = csr_data;
         end else if (csr_index == tchp_pkg::CSR_MAX_MEMBERS) begin
            cfg_in.max_members = csr_data[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bytes   <= tchp_pkg::MAX_BYTES_RESET;
         cfg_ff.max_members <= tchp_pkg::MAX_MEMBERS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tchp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cmd    (front_cmd)
   );

   tchp_fifo #(
      .WIDTH ($bits(tchp_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   tchp_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   tchp_fifo #(
      .WIDTH ($bits(tchp_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
`default_nettype wire

@@ sim/tb_trace_context_header_parser.sv @@
// Testbench for trace_context_header_parser: table-driven values, then random traffic.
`timescale 1ns / 100ps
module tb_trace_context_header_parser;

   typedef logic [7:0] byte_q_type[$];

   typedef enum logic [1:0] {ROW_TP, ROW_TS, ROW_MIX, ROW_CSR} row_op_type;
   typedef enum logic [1:0] {EXP_MODEL, EXP_REJECT, EXP_TS_ACCEPT, EXP_SAMPLE} row_check_type;

   typedef struct packed {
      row_op_type    op;
      logic [7:0]    poke_pos;
      logic [7:0]    poke_val;
      logic [7:0]    csr_idx;
      logic [9:0]    csr_val;
      row_check_type check;
   } dir_row_type;

   localparam int          COUNT_BITS   = 11;
   localparam int          DIR_ROWS     = 28;
   localparam int          NUM_PHASES   = 5;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          HOLD_CYCLES  = 150;
   localparam logic [7:0]  NO_POKE      = 8'hFF;
   localparam logic [7:0]  CSR_UNMAPPED = 8'd2;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam string TP_SAMPLE = "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01";
   localparam string MIX_STATE = "k=v,x=y";

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_SAMPLE},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_MODEL},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  8'd10,   8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  8'd57,   8'h00, 8'h00, 10'd0, EXP_MODEL},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_MODEL},
      '{ROW_TP,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TP,  8'd2,    8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_MIX, NO_POKE, 8'h00, 8'h00, 10'd0, EXP_MODEL},
      '{ROW_TS,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_TS_ACCEPT},
      '{ROW_TS,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_MODEL},
      '{ROW_TS,  8'd1,    tchp_pkg::CHAR_DEL, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TS,  8'd0,    8'h1F, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_TS,  8'd2,    8'hFF, 8'h00, 10'd0, EXP_MODEL},
      '{ROW_TS,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_TS_ACCEPT},
      '{ROW_CSR, NO_POKE, 8'h00, tchp_pkg::CSR_MAX_BYTES,   10'd0,    EXP_MODEL},
      '{ROW_TS,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_CSR, NO_POKE, 8'h00, tchp_pkg::CSR_MAX_BYTES,   10'd1023, EXP_MODEL},
      '{ROW_CSR, NO_POKE, 8'h00, tchp_pkg::CSR_MAX_MEMBERS, 10'd0,    EXP_MODEL},
      '{ROW_TS,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_REJECT},
      '{ROW_CSR, NO_POKE, 8'h00, CSR_UNMAPPED,              10'd5,    EXP_MODEL},
      '{ROW_CSR, NO_POKE, 8'h00, tchp_pkg::CSR_MAX_MEMBERS, 10'h3FF,  EXP_MODEL},
      '{ROW_TS,  NO_POKE, 8'h00, 8'h00, 10'd0, EXP_MODEL}
   };

   string dir_text [DIR_ROWS] = '{
      TP_SAMPLE,
      "ff-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
      "00-00000000000000000000000000000000-00f067aa0ba902b7-01",
      "00-4bf92f3577b34da6a3ce929d0e0e4736-0000000000000000-01",
      "00-4BF92F3577B34DA6A3CE929D0E0E4736-00F067AA0BA902B7-01",
      "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-0",
      {TP_SAMPLE, "-x"},
      {TP_SAMPLE, "x"},
      TP_SAMPLE,
      {TP_SAMPLE, "-abc"},
      "fe-ffffffffffffffffffffffffffffffff-ffffffffffffffff-ff",
      "0",
      TP_SAMPLE,
      TP_SAMPLE,
      "a=1",
      "a=1,b=2,c=3",
      "a=1",
      "a=1",
      "a=1",
      " ",
      "",
      "a=1",
      "",
      "",
      "a",
      "",
      "",
      "a,b"
   };

   logic              clock;
   logic              reset;
   logic              req_push;
   tchp_pkg::req_type req_data;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop;
   tchp_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_index;
   logic [9:0]        csr_data;

   // header predictor state
   logic [5:0]            tp_pos;
   bit                    tp_ok;
   bit                    tp_trace_nz;
   bit                    tp_span_nz;
   logic [7:0]            tp_version;
   logic [127:0]          tp_trace;
   logic [63:0]           tp_span;
   logic [7:0]            tp_flags;
   logic [COUNT_BITS-1:0] ts_count;
   logic [8:0]            ts_commas;
   bit                    ts_ok;
   logic [9:0]            lim_bytes;
   logic [7:0]            lim_members;

   tchp_pkg::rsp_type verdict_q[$];
   tchp_pkg::rsp_type typed_want;
   int      typed_asked = 0;
   int      typed_used = 0;
   int      mismatches = 0;
   int      hold_asks = 0;
   int      holds_served = 0;
   bit      calm = 1'b0;

   trace_context_header_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic void clear_parent_acc();
      tp_pos      = '0;
      tp_ok       = 1'b1;
      tp_trace_nz = 1'b0;
      tp_span_nz  = 1'b0;
      tp_version  = '0;
      tp_trace    = '0;
      tp_span     = '0;
      tp_flags    = '0;
   endfunction

   function automatic void clear_state_acc();
      ts_count  = '0;
      ts_commas = '0;
      ts_ok     = 1'b1;
   endfunction

   // Advances the predictor by one byte; returns 1 when the byte closes a value.
   function automatic bit predict_verdict(input tchp_pkg::req_type item,
                                          output tchp_pkg::rsp_type verdict);
      logic [5:0] pos;
      logic [3:0] nib;
      bit         is_hex;
      logic [7:0] b;
      verdict = '0;
      b = item.data_byte;
      if (item.mode == 1'b0) begin
         pos = tp_pos;
         if (pos != tchp_pkg::POS_SATURATE) tp_pos = pos + 6'd1;
         if (pos == tchp_pkg::POS_SEP_VERSION || pos == tchp_pkg::POS_SEP_TRACE ||
             pos == tchp_pkg::POS_SEP_PARENT || pos == tchp_pkg::HEADER_VALUE_BYTES) begin
            if (b != tchp_pkg::CHAR_DASH) tp_ok = 1'b0;
         end else if (pos < tchp_pkg::HEADER_VALUE_BYTES) begin
            is_hex = 1'b1;
            nib = '0;
            if (b >= tchp_pkg::CHAR_ZERO && b <= tchp_pkg::CHAR_NINE) nib = b[3:0];
            else if (b >= tchp_pkg::CHAR_A && b <= tchp_pkg::CHAR_F) nib = b[3:0] + 4'd9;
            else is_hex = 1'b0;
            if (!is_hex) begin
               tp_ok = 1'b0;
            end else if (pos < tchp_pkg::POS_SEP_VERSION) begin
               tp_version = {tp_version[3:0], nib};
            end else if (pos < tchp_pkg::POS_SEP_TRACE) begin
               tp_trace = {tp_trace[123:0], nib};
               if (nib != 4'd0) tp_trace_nz = 1'b1;
            end else if (pos < tchp_pkg::POS_SEP_PARENT) begin
               tp_span = {tp_span[59:0], nib};
               if (nib != 4'd0) tp_span_nz = 1'b1;
            end else begin
               tp_flags = {tp_flags[3:0], nib};
            end
         end
         if (!item.last) return 1'b0;
         if (tp_ok && tp_pos >= tchp_pkg::HEADER_VALUE_BYTES &&
             tp_version != tchp_pkg::VERSION_INVALID && tp_trace_nz && tp_span_nz) begin
            verdict.accepted      = 1'b1;
            verdict.version       = tp_version;
            verdict.trace_id_high = tp_trace[127:64];
            verdict.trace_id_low  = tp_trace[63:0];
            verdict.span_id       = tp_span;
            verdict.flags         = tp_flags;
         end
         clear_parent_acc();
      end else begin
         if (ts_count != COUNT_MAX) ts_count = ts_count + 1'b1;
         if (b < tchp_pkg::CHAR_SPACE || b == tchp_pkg::CHAR_DEL) ts_ok = 1'b0;
         if (b == tchp_pkg::CHAR_COMMA && ts_commas != tchp_pkg::COMMA_SATURATE)
            ts_commas = ts_commas + 9'd1;
         if (!item.last) return 1'b0;
         verdict.kind     = 1'b1;
         verdict.accepted = ts_ok && ts_count != '0 && ts_count <= lim_bytes &&
                            ({1'b0, ts_commas} + 10'd1) <= {2'b00, lim_members};
         clear_state_acc();
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      tchp_pkg::rsp_type verdict;
      tchp_pkg::rsp_type want;
      if (reset) begin
         clear_parent_acc();
         clear_state_acc();
         lim_bytes   = tchp_pkg::MAX_BYTES_RESET;
         lim_members = tchp_pkg::MAX_MEMBERS_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tchp_pkg::CSR_MAX_BYTES) lim_bytes = csr_data;
            else if (csr_index == tchp_pkg::CSR_MAX_MEMBERS) lim_members = csr_data[7:0];
         end
         if (req_push && !req_full) begin
            if (predict_verdict(req_data, verdict)) begin
               if (typed_used != typed_asked) begin
                  verdict = typed_want;
                  typed_used++;
               end
               verdict_q.push_back(verdict);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (verdict_q.size() == 0) begin
               $error("verdict transfer with nothing expected");
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.kind != want.kind) begin
                  $error("kind: expected %0h, got %0h", want.kind, rsp_data.kind);
                  mismatches++;
               end
               if (rsp_data.accepted != want.accepted) begin
                  $error("accepted: expected %0h, got %0h", want.accepted, rsp_data.accepted);
                  mismatches++;
               end
               if (rsp_data.version != want.version) begin
                  $error("version: expected %h, got %h", want.version, rsp_data.version);
                  mismatches++;
               end
               if (rsp_data.trace_id_high != want.trace_id_high) begin
                  $error("trace_id_high: expected %h, got %h",
                         want.trace_id_high, rsp_data.trace_id_high);
                  mismatches++;
               end
               if (rsp_data.trace_id_low != want.trace_id_low) begin
                  $error("trace_id_low: expected %h, got %h",
                         want.trace_id_low, rsp_data.trace_id_low);
                  mismatches++;
               end
               if (rsp_data.span_id != want.span_id) begin
                  $error("span_id: expected %h, got %h", want.span_id, rsp_data.span_id);
                  mismatches++;
               end
               if (rsp_data.flags != want.flags) begin
                  $error("flags: expected %h, got %h", want.flags, rsp_data.flags);
                  mismatches++;
               end
            end
         end
      end
   end

   // verdict side: random pop, with one long hold-off on request
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_asks) begin
            holds_served++;
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_pop = calm || ($urandom_range(99) >= 16);
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? tchp_pkg::CHAR_ZERO + nib : tchp_pkg::CHAR_A + (nib - 4'd10);
   endfunction

   function automatic byte_q_type text_bytes(input string s);
      byte_q_type v;
      v = {};
      for (int i = 0; i < s.len(); i++) v.push_back(s[i]);
      return v;
   endfunction

   function automatic byte_q_type build_parent();
      byte_q_type v;
      bit         zero_trace;
      bit         zero_span;
      int         n;
      zero_trace = ($urandom_range(11) == 0);
      zero_span  = ($urandom_range(11) == 0);
      v = {};
      if ($urandom_range(15) == 0) begin
         v.push_back(tchp_pkg::CHAR_F);
         v.push_back(tchp_pkg::CHAR_F);
      end else begin
         v.push_back(hex_char(4'($urandom_range(15))));
         v.push_back(hex_char(4'($urandom_range(15))));
      end
      v.push_back(tchp_pkg::CHAR_DASH);
      repeat (32)
         v.push_back(zero_trace ? tchp_pkg::CHAR_ZERO : hex_char(4'($urandom_range(15))));
      v.push_back(tchp_pkg::CHAR_DASH);
      repeat (16)
         v.push_back(zero_span ? tchp_pkg::CHAR_ZERO : hex_char(4'($urandom_range(15))));
      v.push_back(tchp_pkg::CHAR_DASH);
      v.push_back(hex_char(4'($urandom_range(15))));
      v.push_back(hex_char(4'($urandom_range(15))));
      if ($urandom_range(4) == 0) begin
         v.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : tchp_pkg::CHAR_DASH);
         n = $urandom_range(6);
         repeat (n) v.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(4) == 0) v[$urandom_range(v.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(15) == 0)
         v[$urandom_range(54)] = CHAR_UPPER_A + 8'($urandom_range(5));
      if ($urandom_range(9) == 0) v = v[0:$urandom_range(v.size() - 1)];
      return v;
   endfunction

   function automatic byte_q_type build_state(input int cap);
      byte_q_type v;
      int         n;
      int         r;
      v = {};
      n = $urandom_range(cap, 1);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 20) v.push_back(tchp_pkg::CHAR_COMMA);
         else if (r < 23) v.push_back(8'($urandom_range(255)));
         else if (r < 25)
            v.push_back($urandom_range(1) ? tchp_pkg::CHAR_DEL : 8'($urandom_range(31)));
         else v.push_back(8'($urandom_range(126, 32)));
      end
      return v;
   endfunction

   task automatic push_byte(input tchp_pkg::req_type item);
      while (!calm && $urandom_range(99) < 16) @(negedge clock);
      req_push = 1'b1;
      req_data = item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      req_push = 1'b0;
   endtask

   task automatic send_value(input logic mode, input byte_q_type v);
      tchp_pkg::req_type item;
      foreach (v[i]) begin
         item.mode      = mode;
         item.data_byte = v[i];
         item.last      = (i == v.size() - 1);
         push_byte(item);
      end
   endtask

   // traceparent bytes in a, tracestate bytes in b, interleaved at random
   task automatic send_mixed(input byte_q_type a, input byte_q_type b);
      tchp_pkg::req_type item;
      int                ia;
      int                ib;
      ia = 0;
      ib = 0;
      while (ia < a.size() || ib < b.size()) begin
         if (ib >= b.size() || (ia < a.size() && $urandom_range(1) == 1)) begin
            item.mode      = 1'b0;
            item.data_byte = a[ia];
            item.last      = (ia == a.size() - 1);
            ia++;
         end else begin
            item.mode      = 1'b1;
            item.data_byte = b[ib];
            item.last      = (ib == b.size() - 1);
            ib++;
         end
         push_byte(item);
      end
   endtask

   task automatic write_limit(input logic [7:0] idx, input logic [9:0] val);
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      dir_row_type row;
      byte_q_type  value;
      byte_q_type  tp;
      byte_q_type  ts;
      logic [9:0]  lb;
      logic [7:0]  lm;
      int          cap;
      int          pick;
      int          phase_bytes;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      typed_want = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = dir_rows[r];
         if (row.op == ROW_CSR) begin
            write_limit(row.csr_idx, row.csr_val);
         end else begin
            value = text_bytes(dir_text[r]);
            if (row.poke_pos != NO_POKE) value[row.poke_pos] = row.poke_val;
            if (row.check != EXP_MODEL) begin
               typed_want          = '0;
               typed_want.kind     = (row.op == ROW_TS);
               typed_want.accepted = (row.check != EXP_REJECT);
               if (row.check == EXP_SAMPLE) begin
                  typed_want.trace_id_high = 64'h4bf92f3577b34da6;
                  typed_want.trace_id_low  = 64'ha3ce929d0e0e4736;
                  typed_want.span_id       = 64'h00f067aa0ba902b7;
                  typed_want.flags         = 8'h01;
               end
               typed_asked++;
            end
            if (row.op == ROW_MIX) send_mixed(value, text_bytes(MIX_STATE));
            else send_value(row.op == ROW_TS, value);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         unique case (phase)
            0: begin
               lb = 10'd1023;
               lm = 8'd255;
            end
            1: begin
               lb = 10'd1;
               lm = 8'd1;
            end
            2: begin
               lb = 10'($urandom_range(40, 1));
               lm = 8'($urandom_range(8, 1));
            end
            3: begin
               lb = tchp_pkg::MAX_BYTES_RESET;
               lm = tchp_pkg::MAX_MEMBERS_RESET;
            end
            default: begin
               lb = 10'($urandom_range(1023));
               lm = 8'($urandom_range(255));
            end
         endcase
         write_limit(tchp_pkg::CSR_MAX_BYTES, lb);
         write_limit(tchp_pkg::CSR_MAX_MEMBERS, {2'b00, lm});
         calm = (phase == 3);
         cap = int'(lb) + 2;
         if (cap > 40) cap = 40;
         phase_bytes = 0;
         if (phase == 2) begin
            // receiver stalls while short values keep coming, so the block backs up
            hold_asks++;
            repeat (30) begin
               value = {};
               value.push_back(8'($urandom_range(126, 32)));
               send_value(1'b1, value);
            end
         end
         while (phase_bytes < (calm ? 60 : 15)) begin
            pick = $urandom_range(99);
            tp = build_parent();
            ts = build_state(cap);
            if (pick < 35) begin
               send_value(1'b0, tp);
               phase_bytes += tp.size();
            end else if (pick < 75) begin
               send_value(1'b1, ts);
               phase_bytes += ts.size();
            end else if (pick < 88) begin
               send_mixed(tp, ts);
               phase_bytes += tp.size() + ts.size();
            end else begin
               value = {};
               repeat ($urandom_range(8, 1)) value.push_back(8'($urandom_range(255)));
               send_value(1'($urandom_range(1)), value);
               phase_bytes += value.size();
            end
         end
      end
      calm = 1'b0;

      while (verdict_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ trace_context_header_parser.f @@
sv/tchp_pkg.sv
sv/tchp_fifo.sv
sv/tchp_front.sv
sv/tchp_back.sv
sv/trace_context_header_parser.sv
sim/tb_trace_context_header_parser.sv
